FILE: src/armed_relay_run_timer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the armed relay run timer unit
// Shared clocking and reset qualification for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ARMED_RELAY_RUN_TIMER_UNIT_ASSERT_SVH
`define ARMED_RELAY_RUN_TIMER_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define ARRT_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that must be followed by another in the cycle after it.
`define ARRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/arrt_pkg.sv
// ----------------------------------------------------------------------------
// Armed relay run timer package
// Word types, function codes and register map constants.
// ----------------------------------------------------------------------------
package arrt_pkg;

	// Number of slots in each bank of the register map.
	localparam int MAP_SLOTS = 8;

	// Function codes of an input word.
	localparam logic [2:0] FUNC_TICK     = 3'd0;
	localparam logic [2:0] FUNC_COIL_WR  = 3'd1;
	localparam logic [2:0] FUNC_HOLD_WR  = 3'd2;
	localparam logic [2:0] FUNC_COIL_RD  = 3'd3;
	localparam logic [2:0] FUNC_HOLD_RD  = 3'd4;

	// Register map base addresses.
	localparam logic [15:0] ADDR_MANUAL   = 16'd0;
	localparam logic [15:0] ADDR_ARM      = 16'd20;
	localparam logic [15:0] ADDR_TRIGGER  = 16'd30;
	localparam logic [15:0] ADDR_ANY      = 16'd40;
	localparam logic [15:0] ADDR_STOP     = 16'd60;
	localparam logic [15:0] ADDR_DURATION = 16'd100;
	localparam logic [15:0] ADDR_SLOTS    = 16'd8;

	// Fitted channel count after reset.
	localparam logic [3:0] RELAY_COUNT_RESET = 4'd8;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] address;
		logic [15:0] value;
	} in_word_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [7:0]  relay_outputs;
		logic        any_on;
		logic        unmapped;
	} out_word_t;

endpackage

FILE: src/arrt_chan.sv
// ----------------------------------------------------------------------------
// Armed relay run timer channel
// Holds one channel's run start time and length and flags the end of a run.
// ----------------------------------------------------------------------------
module arrt_chan
	import arrt_pkg::*;
(
	input  logic        clk,
	input  logic        load,
	input  logic [31:0] time_now,
	input  logic [15:0] duration,
	output logic        expired
);

	logic [31:0] run_start_q;
	logic [15:0] run_length_q;
	logic [31:0] elapsed;

	// Latch the start time and length when a run is triggered.
	always_ff @(posedge clk) begin
		if (load) begin
			run_start_q  <= time_now;
			run_length_q <= duration;
		end
	end

	// A run starting in this pass has zero elapsed time, so it ends only on a zero length.
	assign elapsed = time_now - run_start_q;
	assign expired = load ? (duration == 16'd0) : (elapsed >= {16'd0, run_length_q});

endmodule

FILE: src/armed_relay_run_timer_unit.sv
// An accepted word is held in the input stage, then registered as a result word.
// One word per cycle while results drain; access and evaluation pass are combinational.
// The result register lets an empty input stage take a word while a result waits.
// Reset clears time, durations, coils, flags and relays, and sets eight fitted channels.
// Run start and length registers are not reset; they are loaded by a trigger before use.
// ----------------------------------------------------------------------------
// Armed relay run timer unit
// Relay bank behind a coil and holding register map with armed timed runs.
// ----------------------------------------------------------------------------
`include "armed_relay_run_timer_unit_assert.svh"

module armed_relay_run_timer_unit
	import arrt_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [3:0] cfg_wdata,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	// Input stage.
	logic     valid_s1;
	in_word_t item_s1;
	logic     adv;
	logic     in_fire;

	// Block state.
	logic [3:0]           relay_count_q;
	logic [31:0]          time_q;
	logic [15:0]          dur_q [MAP_SLOTS];
	logic [MAP_SLOTS-1:0] manual_q;
	logic [MAP_SLOTS-1:0] arm_q;
	logic [MAP_SLOTS-1:0] armed_q;
	logic [MAP_SLOTS-1:0] timed_q;
	logic [MAP_SLOTS-1:0] relay_q;
	logic                 trig_q;
	logic                 stop_q;
	logic                 any_q;

	// Address decode.
	logic [15:0] arm_off;
	logic [15:0] dur_off;
	logic [2:0]  man_idx;
	logic [2:0]  arm_idx;
	logic [2:0]  dur_idx;
	logic        is_man;
	logic        is_arm;
	logic        is_trig;
	logic        is_any;
	logic        is_stop;
	logic        is_coil;
	logic        is_hreg;
	logic        wbit;

	// State after the access.
	logic [31:0]          time_a;
	logic [15:0]          dur_a [MAP_SLOTS];
	logic [MAP_SLOTS-1:0] manual_a;
	logic [MAP_SLOTS-1:0] arm_a;
	logic                 trig_a;
	logic                 stop_a;
	logic                 any_a;
	logic [15:0]          rd;
	logic                 miss;

	// State after the pass.
	logic [15:0]          dur_n [MAP_SLOTS];
	logic [MAP_SLOTS-1:0] manual_n;
	logic [MAP_SLOTS-1:0] arm_n;
	logic [MAP_SLOTS-1:0] armed_n;
	logic [MAP_SLOTS-1:0] timed_n;
	logic [MAP_SLOTS-1:0] relay_n;
	logic                 trig_n;
	logic                 stop_n;
	logic                 any_n;

	// Pass helpers.
	logic [MAP_SLOTS-1:0] chan_mask;
	logic [MAP_SLOTS-1:0] fit_mask;
	logic [MAP_SLOTS-1:0] armed1;
	logic [MAP_SLOTS-1:0] start;
	logic [MAP_SLOTS-1:0] expired;
	logic [MAP_SLOTS-1:0] shown;

	// Output register.
	logic      out_valid_q;
	out_word_t out_data_q;

	// Handshake: the input stage moves on when the result register is free or drains.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_data;
		end
	end

	// Channel masks: channels built into this instance and channels fitted by software.
	always_comb begin
		for (int i = 0; i < MAP_SLOTS; i++) begin
			chan_mask[i] = (i < CHANNELS);
			fit_mask[i]  = chan_mask[i] && (4'(i) < relay_count_q);
		end
	end

	// Register map decode.
	assign arm_off = item_s1.address - ADDR_ARM;
	assign dur_off = item_s1.address - ADDR_DURATION;
	assign man_idx = item_s1.address[2:0];
	assign arm_idx = arm_off[2:0];
	assign dur_idx = dur_off[2:0];
	assign is_man  = item_s1.address < ADDR_MANUAL + ADDR_SLOTS;
	assign is_arm  = (item_s1.address >= ADDR_ARM) && (item_s1.address < ADDR_ARM + ADDR_SLOTS);
	assign is_trig = item_s1.address == ADDR_TRIGGER;
	assign is_any  = item_s1.address == ADDR_ANY;
	assign is_stop = item_s1.address == ADDR_STOP;
	assign is_coil = is_man || is_arm || is_trig || is_any || is_stop;
	assign is_hreg = (item_s1.address >= ADDR_DURATION)
		&& (item_s1.address < ADDR_DURATION + ADDR_SLOTS);
	assign wbit    = item_s1.value[0];

	// Access phase: apply the tick, write or read to the current state.
	always_comb begin
		time_a   = time_q;
		manual_a = manual_q;
		arm_a    = arm_q;
		trig_a   = trig_q;
		stop_a   = stop_q;
		any_a    = any_q;
		rd       = 16'd0;
		miss     = 1'b0;
		for (int i = 0; i < MAP_SLOTS; i++) begin
			dur_a[i] = dur_q[i];
		end
		unique case (item_s1.func)
			FUNC_TICK: begin
				time_a = time_q + 32'd1;
			end
			FUNC_COIL_WR: begin
				if (is_man) begin
					manual_a[man_idx] = wbit;
				end else if (is_arm) begin
					arm_a[arm_idx] = wbit;
				end else if (is_trig) begin
					trig_a = wbit;
				end else if (is_any) begin
					any_a = wbit;
				end else if (is_stop) begin
					stop_a = wbit;
				end
				miss = !is_coil;
			end
			FUNC_HOLD_WR: begin
				if (is_hreg) begin
					dur_a[dur_idx] = item_s1.value;
				end
				miss = !is_hreg;
			end
			FUNC_COIL_RD: begin
				if (is_man) begin
					rd = {15'd0, manual_q[man_idx]};
				end else if (is_arm) begin
					rd = {15'd0, arm_q[arm_idx]};
				end else if (is_trig) begin
					rd = {15'd0, trig_q};
				end else if (is_any) begin
					rd = {15'd0, any_q};
				end else if (is_stop) begin
					rd = {15'd0, stop_q};
				end
				miss = !is_coil;
			end
			FUNC_HOLD_RD: begin
				if (is_hreg) begin
					rd = dur_q[dur_idx];
				end
				miss = !is_hreg;
			end
			default: begin
			end
		endcase
	end

	// Arming and trigger: armed, idle, fitted channels start a run on the trigger.
	assign armed1 = armed_q | (arm_a & fit_mask);
	assign start  = trig_a ? (armed1 & ~timed_q & fit_mask) : '0;

	// Per-channel run timers.
	for (genvar g = 0; g < MAP_SLOTS; g++) begin : g_chan
		if (g < CHANNELS) begin : g_fit
			arrt_chan u_chan (
				.clk      (clk),
				.load     (adv && !stop_a && start[g]),
				.time_now (time_a),
				.duration (dur_a[g]),
				.expired  (expired[g])
			);
		end else begin : g_none
			assign expired[g] = 1'b0;
		end
	end

	// Evaluation pass.
	always_comb begin
		for (int i = 0; i < MAP_SLOTS; i++) begin
			dur_n[i] = dur_a[i];
		end
		arm_n    = arm_a;
		trig_n   = trig_a;
		stop_n   = 1'b0;
		any_n    = any_a;
		if (stop_a) begin
			// Emergency stop clears relays, manual coils, durations, armed and run flags.
			manual_n = '0;
			armed_n  = '0;
			timed_n  = '0;
			relay_n  = '0;
			for (int i = 0; i < MAP_SLOTS; i++) begin
				dur_n[i] = 16'd0;
			end
		end else begin
			arm_n    = arm_a & ~fit_mask;
			trig_n   = 1'b0;
			armed_n  = armed1 & ~start;
			timed_n  = timed_q | start;
			relay_n  = relay_q | start;
			manual_n = manual_a | start;
			// Running channels end on expiry; idle fitted channels follow their manual coil.
			for (int i = 0; i < MAP_SLOTS; i++) begin
				if (fit_mask[i]) begin
					if (timed_n[i]) begin
						if (expired[i]) begin
							relay_n[i]  = 1'b0;
							manual_n[i] = 1'b0;
							timed_n[i]  = 1'b0;
						end
					end else begin
						relay_n[i] = manual_n[i];
					end
				end
			end
			any_n = |(relay_n & fit_mask);
		end
	end

	assign shown = relay_n & fit_mask;

	// State registers update once per processed word; cfg_we writes the channel count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_count_q <= RELAY_COUNT_RESET;
			time_q        <= 32'd0;
			manual_q      <= '0;
			arm_q         <= '0;
			armed_q       <= '0;
			timed_q       <= '0;
			relay_q       <= '0;
			trig_q        <= 1'b0;
			stop_q        <= 1'b0;
			any_q         <= 1'b0;
			for (int i = 0; i < MAP_SLOTS; i++) begin
				dur_q[i] <= 16'd0;
			end
		end else begin
			if (cfg_we) begin
				relay_count_q <= cfg_wdata;
			end
			if (adv) begin
				time_q   <= time_a;
				manual_q <= manual_n;
				arm_q    <= arm_n;
				armed_q  <= armed_n;
				timed_q  <= timed_n;
				relay_q  <= relay_n;
				trig_q   <= trig_n;
				stop_q   <= stop_n;
				any_q    <= any_n;
				for (int i = 0; i < MAP_SLOTS; i++) begin
					dur_q[i] <= dur_n[i];
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.read_data     <= rd;
			out_data_q.relay_outputs <= shown;
			out_data_q.any_on        <= |shown;
			out_data_q.unmapped      <= miss;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A word that leaves the input stage shows up in the result register.
	`ARRT_ASSERT_NEXT(a_adv_to_out, adv, out_valid_q, "processed word did not reach the output")
	// A running channel always drives its relay.
	`ARRT_ASSERT_ALWAYS(a_timed_drives, (timed_q & ~relay_q) == '0, "running channel not driven")
	// Runs exist only on channels that are built in.
	`ARRT_ASSERT_ALWAYS(a_timed_built, (timed_q & ~chan_mask) == '0, "run on absent channel")

endmodule

FILE: bench/armed_relay_run_timer_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Armed relay run timer unit checker
// Watches the input, result and configuration ports of the relay timer and
// keeps a private copy of its register map and run state. Every accepted input
// word is applied to that copy to predict its result word. Every accepted
// result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module armed_relay_run_timer_unit_checker
	import arrt_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	input  logic       in_valid,
	input  logic       in_ready,
	input  in_word_t   in_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  out_word_t  out_data,
	output int         fail_count,
	output int         pending
);

	// Shadow copy of the relay bank.
	logic [31:0] time_ms;
	logic [31:0] run_begin [MAP_SLOTS];
	logic [15:0] run_len   [MAP_SLOTS];
	logic [15:0] dur_reg   [MAP_SLOTS];
	logic [7:0]  manual_q;
	logic [7:0]  arm_q;
	logic [7:0]  armed_q;
	logic [7:0]  timed_q;
	logic [7:0]  relay_q;
	logic        trig_q;
	logic        stop_q;
	logic        any_q;
	logic [3:0]  count_q;

	// Predicted result words, oldest first.
	out_word_t   predicted_results [$];

	// Channels that take part in the evaluation pass; large counts saturate.
	function automatic int fitted_channels();
		if (count_q > CHANNELS) begin
			return CHANNELS;
		end
		return int'(count_q);
	endfunction

	function automatic logic [7:0] fitted_mask();
		return 8'((32'd1 << fitted_channels()) - 32'd1);
	endfunction

	// Coil write; returns 0 when the address is not a coil.
	function automatic bit coil_write(logic [15:0] a, logic b);
		logic [15:0] off;
		if (a < ADDR_MANUAL + ADDR_SLOTS) begin
			off = a - ADDR_MANUAL;
			manual_q[off[2:0]] = b;
			return 1'b1;
		end
		if (a >= ADDR_ARM && a < ADDR_ARM + ADDR_SLOTS) begin
			off = a - ADDR_ARM;
			arm_q[off[2:0]] = b;
			return 1'b1;
		end
		if (a == ADDR_TRIGGER) begin
			trig_q = b;
			return 1'b1;
		end
		if (a == ADDR_ANY) begin
			any_q = b;
			return 1'b1;
		end
		if (a == ADDR_STOP) begin
			stop_q = b;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Coil read; returns 0 when the address is not a coil.
	function automatic bit coil_read(logic [15:0] a, output logic b);
		logic [15:0] off;
		b = 1'b0;
		if (a < ADDR_MANUAL + ADDR_SLOTS) begin
			off = a - ADDR_MANUAL;
			b = manual_q[off[2:0]];
			return 1'b1;
		end
		if (a >= ADDR_ARM && a < ADDR_ARM + ADDR_SLOTS) begin
			off = a - ADDR_ARM;
			b = arm_q[off[2:0]];
			return 1'b1;
		end
		if (a == ADDR_TRIGGER) begin
			b = trig_q;
			return 1'b1;
		end
		if (a == ADDR_ANY) begin
			b = any_q;
			return 1'b1;
		end
		if (a == ADDR_STOP) begin
			b = stop_q;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit is_duration(logic [15:0] a);
		return a >= ADDR_DURATION && a < ADDR_DURATION + ADDR_SLOTS;
	endfunction

	// Evaluation pass: emergency stop, arming, trigger, timed runs, manual follow.
	function automatic void run_pass();
		int n;
		logic [31:0] elapsed;
		n = fitted_channels();
		if (stop_q) begin
			// The stop pass clears the bank and ends without touching arm,
			// trigger or the any-on coil.
			relay_q = '0;
			manual_q = '0;
			for (int i = 0; i < MAP_SLOTS; i++) begin
				dur_reg[i] = '0;
			end
			timed_q = '0;
			armed_q = '0;
			stop_q = 1'b0;
			return;
		end
		for (int i = 0; i < n; i++) begin
			if (arm_q[i]) begin
				armed_q[i] = 1'b1;
				arm_q[i] = 1'b0;
			end
		end
		if (trig_q) begin
			for (int i = 0; i < n; i++) begin
				if (armed_q[i] && !timed_q[i]) begin
					timed_q[i] = 1'b1;
					run_begin[i] = time_ms;
					run_len[i] = dur_reg[i];
					relay_q[i] = 1'b1;
					manual_q[i] = 1'b1;
					armed_q[i] = 1'b0;
				end
			end
			trig_q = 1'b0;
		end
		for (int i = 0; i < n; i++) begin
			if (timed_q[i]) begin
				elapsed = time_ms - run_begin[i];
				if (elapsed >= {16'd0, run_len[i]}) begin
					relay_q[i] = 1'b0;
					manual_q[i] = 1'b0;
					timed_q[i] = 1'b0;
				end
			end else begin
				relay_q[i] = manual_q[i];
			end
		end
		any_q = |(relay_q & fitted_mask());
	endfunction

	// Applies one input word to the shadow bank and returns its result word.
	function automatic out_word_t apply_word(in_word_t w);
		out_word_t r;
		logic [15:0] off;
		logic b;
		r = '0;
		case (w.func)
			FUNC_TICK: begin
				time_ms = time_ms + 32'd1;
			end
			FUNC_COIL_WR: begin
				if (!coil_write(w.address, w.value[0])) begin
					r.unmapped = 1'b1;
				end
			end
			FUNC_HOLD_WR: begin
				if (is_duration(w.address)) begin
					off = w.address - ADDR_DURATION;
					dur_reg[off[2:0]] = w.value;
				end else begin
					r.unmapped = 1'b1;
				end
			end
			FUNC_COIL_RD: begin
				if (coil_read(w.address, b)) begin
					r.read_data = {15'd0, b};
				end else begin
					r.unmapped = 1'b1;
				end
			end
			FUNC_HOLD_RD: begin
				if (is_duration(w.address)) begin
					off = w.address - ADDR_DURATION;
					r.read_data = dur_reg[off[2:0]];
				end else begin
					r.unmapped = 1'b1;
				end
			end
			default: begin
			end
		endcase
		run_pass();
		r.relay_outputs = relay_q & fitted_mask();
		r.any_on = |r.relay_outputs;
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
		end
	endtask

	// Result words are checked before the input word of the same edge is
	// applied, so the order of the queue always follows acceptance order.
	always @(posedge clk or negedge arst_n) begin : watch
		out_word_t exp_w;
		if (!arst_n) begin
			time_ms = '0;
			for (int i = 0; i < MAP_SLOTS; i++) begin
				run_begin[i] = '0;
				run_len[i] = '0;
				dur_reg[i] = '0;
			end
			manual_q = '0;
			arm_q = '0;
			armed_q = '0;
			timed_q = '0;
			relay_q = '0;
			trig_q = 1'b0;
			stop_q = 1'b0;
			any_q = 1'b0;
			count_q = RELAY_COUNT_RESET;
			predicted_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					fail_count++;
					$display("%0t: result word with nothing expected, expected none, actual %h",
						$time, out_data);
				end else begin
					exp_w = predicted_results.pop_front();
					check_field("read_data", exp_w.read_data, out_data.read_data);
					check_field("relay_outputs", {8'd0, exp_w.relay_outputs},
						{8'd0, out_data.relay_outputs});
					check_field("any_on", {15'd0, exp_w.any_on}, {15'd0, out_data.any_on});
					check_field("unmapped", {15'd0, exp_w.unmapped},
						{15'd0, out_data.unmapped});
				end
			end
			if (cfg_we) begin
				count_q = cfg_wdata;
			end
			if (in_valid && in_ready) begin
				predicted_results.push_back(apply_word(in_data));
			end
			pending = predicted_results.size();
		end
	end

endmodule

FILE: bench/armed_relay_run_timer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Armed relay run timer unit testbench
// Drives register map accesses and millisecond ticks into the relay timer with
// random idle gaps on both sides, walks through several fitted channel counts,
// and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module armed_relay_run_timer_unit_tb;
	import arrt_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int TIMEOUT_NS  = 10_000_000;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [3:0] cfg_wdata = '0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_word_t   in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_word_t  out_data;
	int         fail_total;
	int         words_pending;

	// Pacing controls for the sender and the receiver.
	bit         sender_burst = 1'b0;
	bit         recv_burst   = 1'b0;
	bit         hold_off     = 1'b0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	armed_relay_run_timer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	armed_relay_run_timer_unit_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_total),
		.pending    (words_pending)
	);

	function automatic in_word_t make_word(logic [2:0] f, logic [15:0] a, logic [15:0] v);
		in_word_t w;
		w.func = f;
		w.address = a;
		w.value = v;
		return w;
	endfunction

	// Offers one word after a random idle gap and returns at its acceptance edge.
	// With no gap, valid stays high and only the payload changes.
	task automatic send_word(input in_word_t w);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stops offering and waits until every predicted result word has arrived.
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (words_pending != 0);
		repeat (2) @(posedge clk);
	endtask

	// One phase: a new channel count, then mostly well-formed arm and trigger
	// sequences with random content, mixed with reads, ticks and noise.
	task automatic run_phase(input logic [3:0] count_val, input int items, input bit press,
		input bit pause_mid, input bit burst);
		int sent;
		int r;
		int k;
		logic [15:0] v;
		logic [15:0] a;
		logic [2:0] f;
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= count_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sender_burst = burst;
		recv_burst = burst;
		if (press) begin
			// Receiver holds off while the sender keeps pushing words.
			hold_off = 1'b1;
			sender_burst = 1'b1;
		end
		sent = 0;
		while (sent < items) begin
			if (press && sent == 60) begin
				sender_burst = burst;
			end
			if (pause_mid && sent == items / 2) begin
				settle();
			end
			if ($urandom_range(0, 9) == 0) begin
				// Program durations, arm a random set of channels, trigger, tick.
				for (int i = 0; i < MAP_SLOTS; i++) begin
					v = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 12));
					send_word(make_word(FUNC_HOLD_WR, ADDR_DURATION + 16'(i), v));
					sent++;
				end
				for (int i = 0; i < MAP_SLOTS; i++) begin
					if ($urandom_range(0, 1) == 1) begin
						send_word(make_word(FUNC_COIL_WR, ADDR_ARM + 16'(i), 16'd1));
						sent++;
					end
				end
				send_word(make_word(FUNC_COIL_WR, ADDR_TRIGGER, 16'($urandom()) | 16'd1));
				sent++;
				k = $urandom_range(0, 15);
				for (int i = 0; i < k; i++) begin
					send_word(make_word(FUNC_TICK, 16'($urandom()), 16'($urandom())));
					sent++;
				end
			end else begin
				r = $urandom_range(0, 99);
				v = 16'($urandom());
				if (r < 28) begin
					send_word(make_word(FUNC_TICK, 16'($urandom()), v));
				end else if (r < 42) begin
					send_word(make_word(FUNC_COIL_WR, ADDR_MANUAL + 16'($urandom_range(0, 7)), v));
				end else if (r < 52) begin
					send_word(make_word(FUNC_COIL_WR, ADDR_ARM + 16'($urandom_range(0, 7)), v));
				end else if (r < 58) begin
					send_word(make_word(FUNC_COIL_WR, ADDR_TRIGGER, v));
				end else if (r < 60) begin
					send_word(make_word(FUNC_COIL_WR, ADDR_STOP, v));
				end else if (r < 62) begin
					send_word(make_word(FUNC_COIL_WR, ADDR_ANY, v));
				end else if (r < 70) begin
					if ($urandom_range(0, 3) != 0) begin
						v = 16'($urandom_range(0, 25));
					end
					send_word(make_word(FUNC_HOLD_WR, ADDR_DURATION + 16'($urandom_range(0, 7)), v));
				end else if (r < 78) begin
					k = $urandom_range(0, 18);
					if (k < 8) begin
						a = ADDR_MANUAL + 16'(k);
					end else if (k < 16) begin
						a = ADDR_ARM + 16'(k - 8);
					end else if (k == 16) begin
						a = ADDR_TRIGGER;
					end else if (k == 17) begin
						a = ADDR_ANY;
					end else begin
						a = ADDR_STOP;
					end
					send_word(make_word(FUNC_COIL_RD, a, v));
				end else if (r < 84) begin
					send_word(make_word(FUNC_HOLD_RD, ADDR_DURATION + 16'($urandom_range(0, 7)), v));
				end else if (r < 94) begin
					// Noise: any function, addresses mostly near or outside the map.
					f = 3'($urandom_range(0, 7));
					a = ($urandom_range(0, 1) == 1) ? 16'($urandom()) : 16'($urandom_range(0, 110));
					send_word(make_word(f, a, v));
				end else begin
					f = 3'($urandom_range(5, 7));
					send_word(make_word(f, 16'($urandom()), v));
				end
				sent++;
			end
		end
		sender_burst = 1'b0;
		recv_burst = 1'b0;
	endtask

	// Receiver: a random stall before each result word, and one long hold-off
	// when asked for.
	initial begin : drain
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
			gap = recv_burst ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Stimulus and verdict.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset count of eight channels.
		send_word(make_word(FUNC_HOLD_RD, ADDR_DURATION, 16'h0000));
		send_word(make_word(FUNC_COIL_RD, ADDR_ANY, 16'hFFFF));
		send_word(make_word(FUNC_HOLD_WR, ADDR_DURATION + 16'd7, 16'hFFFF));
		send_word(make_word(FUNC_HOLD_RD, ADDR_DURATION + 16'd7, 16'h0000));
		// Unmapped writes and reads.
		send_word(make_word(FUNC_HOLD_WR, 16'hFFFF, 16'h1234));
		send_word(make_word(FUNC_COIL_WR, 16'hFFFF, 16'hFFFF));
		send_word(make_word(FUNC_COIL_RD, ADDR_MANUAL + ADDR_SLOTS, 16'h0000));
		send_word(make_word(FUNC_HOLD_RD, ADDR_DURATION - 16'd1, 16'h0000));
		// Undefined function codes and a tick with busy address and value bits.
		send_word(make_word(3'd5, 16'hFFFF, 16'hFFFF));
		send_word(make_word(3'd7, 16'h0000, 16'h0000));
		send_word(make_word(FUNC_TICK, 16'hFFFF, 16'hFFFF));
		// Manual follow; only bit 0 of the value counts.
		send_word(make_word(FUNC_COIL_WR, ADDR_MANUAL, 16'hFFFF));
		send_word(make_word(FUNC_COIL_WR, ADDR_MANUAL, 16'hFFFE));
		// Timed runs: channel 1 has a zero duration and ends in its trigger pass.
		send_word(make_word(FUNC_HOLD_WR, ADDR_DURATION, 16'd3));
		send_word(make_word(FUNC_HOLD_WR, ADDR_DURATION + 16'd1, 16'd0));
		send_word(make_word(FUNC_COIL_WR, ADDR_ARM, 16'd1));
		send_word(make_word(FUNC_COIL_WR, ADDR_ARM + 16'd1, 16'd1));
		send_word(make_word(FUNC_COIL_WR, ADDR_ARM + 16'd7, 16'd1));
		send_word(make_word(FUNC_COIL_WR, ADDR_TRIGGER, 16'd1));
		// A manual write during a run leaves the relay driven until the run ends.
		send_word(make_word(FUNC_COIL_WR, ADDR_MANUAL, 16'd0));
		for (int i = 0; i < 3; i++) begin
			send_word(make_word(FUNC_TICK, 16'h0000, 16'h0000));
		end
		// Any-on coil write is overwritten; emergency stop clears the bank.
		send_word(make_word(FUNC_COIL_WR, ADDR_ANY, 16'd1));
		send_word(make_word(FUNC_COIL_WR, ADDR_STOP, 16'd1));
		send_word(make_word(FUNC_HOLD_RD, ADDR_DURATION + 16'd7, 16'h0000));
		send_word(make_word(FUNC_COIL_RD, ADDR_STOP, 16'h0000));

		// Random phases over several channel counts, extremes included.
		run_phase(4'd1, 240, 1'b0, 1'b0, 1'b0);
		run_phase(4'd0, 200, 1'b0, 1'b0, 1'b0);
		run_phase(4'd15, 240, 1'b1, 1'b0, 1'b0);
		run_phase(4'd3, 240, 1'b0, 1'b1, 1'b0);
		run_phase(4'd8, 240, 1'b0, 1'b0, 1'b1);
		run_phase(4'd5, 240, 1'b0, 1'b1, 1'b0);
		run_phase(4'd9, 240, 1'b0, 1'b0, 1'b0);
		run_phase(4'd8, 240, 1'b1, 1'b0, 1'b0);

		settle();
		repeat (4) @(posedge clk);
		if (fail_total == 0 && words_pending == 0) begin
			$display("PASS armed_relay_run_timer_unit");
		end else begin
			$display("FAIL armed_relay_run_timer_unit");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#(TIMEOUT_NS);
		$display("FAIL armed_relay_run_timer_unit");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/arrt_pkg.sv
src/arrt_chan.sv
src/armed_relay_run_timer_unit.sv
bench/armed_relay_run_timer_unit_checker.sv
bench/armed_relay_run_timer_unit_tb.sv
